// ----- rtl/tmsc_pkg.sv -----
// Shared types and constants of the texture mip size calculator.
package tmsc_pkg;

	// Parameter defaults
	localparam int DIM_BITS_DEF   = 16;
	localparam int MAX_LEVELS_DEF = 17;

	// Stream payload layout
	localparam int TDATA_W = 64;
	localparam int SIZE_W  = 64;
	localparam int TEX_W   = 16;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int W_LSB   = 0;
	localparam int H_LSB   = 16;
	localparam int D_LSB   = 32;
	localparam int IDX_LSB = 48;
	localparam int CNT_LSB = 52;

	// Shared multiplier operand width
	localparam int MUL_W = 32;

	// Configuration registers
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 5;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_BLOCK = 2'd2;
	localparam logic [CFG_W-1:0] BLOCK_WIDTH_RST     = 5'd1;
	localparam logic [CFG_W-1:0] BLOCK_HEIGHT_RST    = 5'd1;
	localparam logic [CFG_W-1:0] BYTES_PER_BLOCK_RST = 5'd4;

	// Opcodes
	localparam logic OP_LEVEL = 1'b0;
	localparam logic OP_CHAIN = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_step;
		logic mul_bb;
		logic mul_lo;
		logic mul_hi;
		logic acc;
		logic push;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic lvl_zero;
		logic lvl_last;
	} stat_t;

endpackage

// ----- rtl/texture_mip_size_calculator.sv -----
// Top level of the texture mip size calculator.
// Each request returns one byte size: the size of one mip level (tuser 0) or the sum of
// the first mip_count levels (tuser 1, count saturated to MAX_LEVELS). One request is
// worked at a time: an accept step, the bit-serial block dividers, then per level the
// block product and the low and high partial products on the shared 32 x 32 multiplier
// and an accumulate step, and last a hand-off of the result to the output register that
// waits while that register is still full. Later levels reuse the first quotient by halving.
// A finished result waits in the output register while the next request is taken.
// Configuration may be written only while no request is in progress.
module texture_mip_size_calculator #(
	parameter int DIM_BITS   = tmsc_pkg::DIM_BITS_DEF,
	parameter int MAX_LEVELS = tmsc_pkg::MAX_LEVELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tex_width[15:0], tex_height[31:16], tex_depth[47:32], mip_index[51:48],
	// mip_count[56:52], zero fill above
	input  logic [tmsc_pkg::TDATA_W-1:0]   s_tdata,
	// opcode[0]
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// size_bytes[63:0]
	output logic [tmsc_pkg::SIZE_W-1:0]    m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tmsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tmsc_pkg::CFG_W-1:0]     cfg_data
);

	tmsc_pkg::cmd_t  cmd;
	tmsc_pkg::stat_t st;

	// Register writes always complete
	assign cfg_ready = 1'b1;

	tmsc_ctrl #(
		.DIM_BITS (DIM_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	tmsc_datapath #(
		.DIM_BITS   (DIM_BITS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.st        (st),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- rtl/tmsc_datapath.sv -----
// Datapath of the mip size calculator: config registers, dividers, multiplier, accumulator.
module tmsc_datapath #(
	parameter int DIM_BITS   = tmsc_pkg::DIM_BITS_DEF,
	parameter int MAX_LEVELS = tmsc_pkg::MAX_LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [tmsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmsc_pkg::CFG_W-1:0]       cfg_data,
	input  logic [tmsc_pkg::TDATA_W-1:0]     s_tdata,
	input  logic [0:0]                       s_tuser,
	input  tmsc_pkg::cmd_t                   cmd,
	output tmsc_pkg::stat_t                  st,
	output logic [tmsc_pkg::SIZE_W-1:0]      m_tdata
);

	localparam int LVL_W = $clog2(MAX_LEVELS + 1);
	localparam int CW    = tmsc_pkg::CFG_W;
	localparam int MW    = tmsc_pkg::MUL_W;

	function automatic logic [DIM_BITS-1:0] shift_floor1(input logic [DIM_BITS-1:0] v,
			input logic [tmsc_pkg::IDX_W-1:0] sh);
		logic [DIM_BITS-1:0] t;
		t = v >> sh;
		return (t == '0) ? DIM_BITS'(1) : t;
	endfunction

	logic [CW-1:0] bw_q, bh_q, bpb_q;
	logic [CW-1:0] blk_div [2];

	logic                      in_op;
	logic [DIM_BITS-1:0]       in_dim [3];
	logic [tmsc_pkg::IDX_W-1:0] in_idx;
	logic [tmsc_pkg::CNT_W-1:0] in_cnt;
	logic [LVL_W-1:0]          in_lvls;

	// Lanes 0 and 1 are width and height; lane 2 is depth (never blocked)
	logic [DIM_BITS-1:0] n_q [3];
	logic [DIM_BITS-1:0] dv_q [2];
	logic [DIM_BITS-1:0] q_q [2];
	logic [CW-1:0]       r_q [2];
	logic [DIM_BITS-1:0] blocks [2];

	logic [CW:0]         div_t [2];
	logic                div_ge [2];
	logic [CW-1:0]       div_r [2];

	logic [LVL_W-1:0]    lvl_q;
	logic [MW-1:0]       mul_a, mul_b;
	logic [2*MW-1:0]     prod;
	logic [63:0]         x_q, y_q, total_q, out_q;

	// Configuration registers; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q  <= tmsc_pkg::BLOCK_WIDTH_RST;
			bh_q  <= tmsc_pkg::BLOCK_HEIGHT_RST;
			bpb_q <= tmsc_pkg::BYTES_PER_BLOCK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tmsc_pkg::REG_BLOCK_WIDTH:     bw_q  <= cfg_data;
				tmsc_pkg::REG_BLOCK_HEIGHT:    bh_q  <= cfg_data;
				tmsc_pkg::REG_BYTES_PER_BLOCK: bpb_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign blk_div[0] = bw_q;
	assign blk_div[1] = bh_q;

	// Unpack the request
	assign in_op     = s_tuser[0];
	assign in_dim[0] = DIM_BITS'(s_tdata[tmsc_pkg::W_LSB +: tmsc_pkg::TEX_W]);
	assign in_dim[1] = DIM_BITS'(s_tdata[tmsc_pkg::H_LSB +: tmsc_pkg::TEX_W]);
	assign in_dim[2] = DIM_BITS'(s_tdata[tmsc_pkg::D_LSB +: tmsc_pkg::TEX_W]);
	assign in_idx    = s_tdata[tmsc_pkg::IDX_LSB +: tmsc_pkg::IDX_W];
	assign in_cnt    = s_tdata[tmsc_pkg::CNT_LSB +: tmsc_pkg::CNT_W];

	// Saturate the level count; a single level query runs one level
	always_comb begin
		if (in_op == tmsc_pkg::OP_LEVEL) begin
			in_lvls = LVL_W'(1);
		end else if (int'(in_cnt) > MAX_LEVELS) begin
			in_lvls = LVL_W'(MAX_LEVELS);
		end else begin
			in_lvls = LVL_W'(in_cnt);
		end
	end

	// Restoring divide step and block count per lane
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			div_t[l]  = {r_q[l], dv_q[l][DIM_BITS-1]};
			div_ge[l] = (div_t[l] >= {1'b0, blk_div[l]});
			div_r[l]  = div_ge[l] ? CW'(div_t[l] - {1'b0, blk_div[l]}) : CW'(div_t[l]);
			blocks[l] = (blk_div[l] == '0) ? '0 :
				q_q[l] + DIM_BITS'(r_q[l] != '0);
		end
	end

	// Lane registers: load, divide, then halve quotient and remainder per level
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int l = 0; l < 3; l++) begin
				n_q[l] <= (in_op == tmsc_pkg::OP_CHAIN) ? in_dim[l] :
					shift_floor1(in_dim[l], in_idx);
			end
			for (int l = 0; l < 2; l++) begin
				dv_q[l] <= (in_op == tmsc_pkg::OP_CHAIN) ? in_dim[l] :
					shift_floor1(in_dim[l], in_idx);
				q_q[l]  <= '0;
				r_q[l]  <= '0;
			end
		end else if (cmd.div_step) begin
			for (int l = 0; l < 2; l++) begin
				dv_q[l] <= {dv_q[l][DIM_BITS-2:0], 1'b0};
				q_q[l]  <= {q_q[l][DIM_BITS-2:0], div_ge[l]};
				r_q[l]  <= div_r[l];
			end
		end else if (cmd.acc) begin
			n_q[2] <= (n_q[2] <= DIM_BITS'(1)) ? DIM_BITS'(1) : (n_q[2] >> 1);
			for (int l = 0; l < 2; l++) begin
				if (n_q[l] <= DIM_BITS'(1)) begin
					n_q[l] <= DIM_BITS'(1);
					q_q[l] <= (blk_div[l] == CW'(1)) ? DIM_BITS'(1) : '0;
					r_q[l] <= (blk_div[l] == CW'(1)) ? '0 : CW'(1);
				end else begin
					n_q[l] <= n_q[l] >> 1;
					q_q[l] <= q_q[l] >> 1;
					r_q[l] <= CW'(({1'b0, r_q[l]} +
						(q_q[l][0] ? {1'b0, blk_div[l]} : '0)) >> 1);
				end
			end
		end
	end

	// Level counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (cmd.load) begin
			lvl_q <= in_lvls;
		end else if (cmd.acc) begin
			lvl_q <= lvl_q - LVL_W'(1);
		end
	end

	assign st.lvl_zero = (lvl_q == '0);
	assign st.lvl_last = (lvl_q == LVL_W'(1));

	// Shared 32 x 32 multiplier
	always_comb begin
		if (cmd.mul_bb) begin
			mul_a = MW'(blocks[0]);
			mul_b = MW'(blocks[1]);
		end else begin
			mul_a = cmd.mul_lo ? x_q[31:0] : x_q[63:32];
			mul_b = MW'(n_q[2]);
		end
	end

	assign prod = {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, mul_b};

	// Image size of one level, modulo 2^64, and the running total
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			total_q <= '0;
		end
		if (cmd.mul_bb) begin
			x_q <= prod;
		end
		if (cmd.mul_lo) begin
			y_q <= prod;
		end else if (cmd.mul_hi) begin
			y_q <= y_q + {prod[31:0], 32'b0};
		end
		if (cmd.acc) begin
			total_q <= total_q + 64'(y_q * {59'b0, bpb_q});
		end
		if (cmd.push) begin
			out_q <= total_q;
		end
	end

	assign m_tdata = out_q;

	a_lvl_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (int'(lvl_q) <= MAX_LEVELS))
		else $error("level count above maximum");

	a_single_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (s_tuser[0] == tmsc_pkg::OP_LEVEL)) |=> (lvl_q == LVL_W'(1)))
		else $error("single level query does not run one level");

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (s_tuser[0] == tmsc_pkg::OP_LEVEL)) |=>
		(n_q[0] != '0 && n_q[1] != '0 && n_q[2] != '0))
		else $error("single level dimension not raised to one");

endmodule

// ----- rtl/tmsc_ctrl.sv -----
// Controller state machine of the mip size calculator.
module tmsc_ctrl #(
	parameter int DIM_BITS = tmsc_pkg::DIM_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	output tmsc_pkg::cmd_t  cmd,
	input  tmsc_pkg::stat_t st
);

	localparam int DIV_CW = $clog2(DIM_BITS);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DIV    = 7'b0000010,
		ST_MUL_BB = 7'b0000100,
		ST_MUL_LO = 7'b0001000,
		ST_MUL_HI = 7'b0010000,
		ST_ACC    = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t              state_q, state_d;
	logic [DIV_CW-1:0]   div_cnt_q;
	logic                m_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == '0) begin
					state_d = st.lvl_zero ? ST_FINISH : ST_MUL_BB;
				end
			end
			ST_MUL_BB: begin
				cmd.mul_bb = 1'b1;
				state_d    = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = st.lvl_last ? ST_FINISH : ST_MUL_BB;
			end
			ST_FINISH: begin
				if (!m_valid_q || m_tready) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, divide step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				div_cnt_q <= DIV_CW'(DIM_BITS - 1);
			end else if (cmd.div_step && div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - DIV_CW'(1);
			end
			if (cmd.push) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DIV && div_cnt_q == DIV_CW'(DIM_BITS - 1)))
		else $error("request accepted without starting the divide");

	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> m_tvalid)
		else $error("result pushed but not presented");

	a_last_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && st.lvl_last) |=> (state_q == ST_FINISH))
		else $error("last level did not finish");

endmodule

// ----- sim/texture_mip_size_calculator_tb.sv -----
// Self-checking testbench for the texture mip size calculator: level and chain sizes.
`timescale 1ns / 1ps

module texture_mip_size_calculator_tb;

	localparam int IDLE_PCT = 38;
	// Index 3 maps to no register; writing it must change nothing
	localparam logic [tmsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// One accepted request and the byte size it must produce
	typedef struct {
		logic        op;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] d;
		logic [3:0]  idx;
		logic [4:0]  cnt;
		logic [63:0] size;
	} size_expect_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [tmsc_pkg::TDATA_W-1:0]   s_tdata   = '0;
	logic [0:0]                     s_tuser   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [tmsc_pkg::SIZE_W-1:0]    m_tdata;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [tmsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tmsc_pkg::CFG_W-1:0]     cfg_data  = '0;

	// Format registers as the block should hold them
	logic [tmsc_pkg::CFG_W-1:0] fmt_block_w   = tmsc_pkg::BLOCK_WIDTH_RST;
	logic [tmsc_pkg::CFG_W-1:0] fmt_block_h   = tmsc_pkg::BLOCK_HEIGHT_RST;
	logic [tmsc_pkg::CFG_W-1:0] fmt_block_bytes = tmsc_pkg::BYTES_PER_BLOCK_RST;

	size_expect_t pending_sizes[$];
	int           mismatch_count = 0;
	bit           no_idle = 1'b0;

	texture_mip_size_calculator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[texture_mip_size_calculator] ERROR");
		$finish;
	end

	// Bytes of one W x H x D image in the current format; depth is not blocked
	function automatic logic [63:0] image_bytes(input logic [63:0] w, h, d);
		logic [63:0] bx, by;
		bx = (fmt_block_w == 0) ? 64'd0 : (w + fmt_block_w - 1) / fmt_block_w;
		by = (fmt_block_h == 0) ? 64'd0 : (h + fmt_block_h - 1) / fmt_block_h;
		return d * bx * by * fmt_block_bytes;
	endfunction

	// Expected size of one level or of the first cnt levels of the chain
	function automatic logic [63:0] mip_bytes(input logic op, input logic [15:0] w, h, d,
			input logic [3:0] idx, input logic [4:0] cnt);
		logic [63:0] total, lw, lh, ld;
		int          levels;
		int          lvl;
		total = '0;
		if (op == tmsc_pkg::OP_LEVEL) begin
			lw = w >> idx;
			lh = h >> idx;
			ld = d >> idx;
			if (lw == 0) lw = 1;
			if (lh == 0) lh = 1;
			if (ld == 0) ld = 1;
			total = image_bytes(lw, lh, ld);
		end else begin
			levels = (cnt > tmsc_pkg::MAX_LEVELS_DEF) ? tmsc_pkg::MAX_LEVELS_DEF : cnt;
			lw = w;
			lh = h;
			ld = d;
			for (lvl = 0; lvl < levels; lvl++) begin
				total += image_bytes(lw, lh, ld);
				lw = (lw >> 1 == 0) ? 64'd1 : lw >> 1;
				lh = (lh >> 1 == 0) ? 64'd1 : lh >> 1;
				ld = (ld >> 1 == 0) ? 64'd1 : ld >> 1;
			end
		end
		return total;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Present one request, hold it until accepted, then record its expected size
	task automatic send_query(input logic op, input logic [15:0] w, h, d,
			input logic [3:0] idx, input logic [4:0] cnt);
		size_expect_t item;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, cnt, idx, d, h, w};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		item.op   = op;
		item.w    = w;
		item.h    = h;
		item.d    = d;
		item.idx  = idx;
		item.cnt  = cnt;
		item.size = mip_bytes(op, w, h, d, idx, cnt);
		pending_sizes.push_back(item);
	endtask

	// Write one register; the caller drops cfg_valid after the last write
	task automatic write_reg(input logic [tmsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [tmsc_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			tmsc_pkg::REG_BLOCK_WIDTH:     fmt_block_w     = val;
			tmsc_pkg::REG_BLOCK_HEIGHT:    fmt_block_h     = val;
			tmsc_pkg::REG_BYTES_PER_BLOCK: fmt_block_bytes = val;
			default: ;
		endcase
	endtask

	task automatic set_format(input logic [tmsc_pkg::CFG_W-1:0] bw, bh, bpb);
		write_reg(tmsc_pkg::REG_BLOCK_WIDTH, bw);
		write_reg(tmsc_pkg::REG_BLOCK_HEIGHT, bh);
		write_reg(tmsc_pkg::REG_BYTES_PER_BLOCK, bpb);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait until every expected size has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_sizes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Dimensions biased toward small values and toward values at, just below and just above a single set bit
	function automatic logic [15:0] pick_dim();
		logic [15:0] p;
		p = 16'd1 << $urandom_range(15);
		case ($urandom_range(3))
			0: return 16'($urandom_range(64));
			1: return 16'($urandom);
			default: begin
				case ($urandom_range(3))
					0: return p;
					1: return p - 16'd1;
					2: return p + 16'd1;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	// Block sizes mostly in the usual range, sometimes above it
	function automatic logic [tmsc_pkg::CFG_W-1:0] pick_block();
		if ($urandom_range(9) == 0)
			return tmsc_pkg::CFG_W'($urandom_range(31, 17));
		return tmsc_pkg::CFG_W'($urandom_range(16));
	endfunction

	task automatic send_random_query();
		logic [4:0] cnt;
		cnt = ($urandom_range(99) < 85) ? 5'($urandom_range(17)) : 5'($urandom_range(31, 18));
		send_query(1'($urandom), pick_dim(), pick_dim(), pick_dim(),
			4'($urandom_range(15)), cnt);
	endtask

	// Level and chain corner cases at the reset format
	task automatic test_directed_levels();
		send_query(tmsc_pkg::OP_LEVEL, 16'd0, 16'd0, 16'd0, 4'd0, 5'd0);
		send_query(tmsc_pkg::OP_LEVEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 5'd31);
		send_query(tmsc_pkg::OP_LEVEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 5'd0);
		send_query(tmsc_pkg::OP_LEVEL, 16'd640, 16'd480, 16'd1, 4'd3, 5'd17);
		send_query(tmsc_pkg::OP_LEVEL, 16'd3, 16'd1, 16'd0, 4'd15, 5'd5);
		send_query(tmsc_pkg::OP_CHAIN, 16'd0, 16'd0, 16'd0, 4'd0, 5'd0);
		send_query(tmsc_pkg::OP_CHAIN, 16'd256, 16'd256, 16'd1, 4'd7, 5'd1);
		send_query(tmsc_pkg::OP_CHAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 5'd17);
		send_query(tmsc_pkg::OP_CHAIN, 16'd1024, 16'd512, 16'd64, 4'd0, 5'd31);
		send_query(tmsc_pkg::OP_CHAIN, 16'd0, 16'd37, 16'd5, 4'd2, 5'd5);
		drain_results();
	endtask

	// Partial blocks, zero block sizes, zero bytes and the unmapped register index
	task automatic test_directed_formats();
		set_format(5'd4, 5'd4, 5'd8);
		send_query(tmsc_pkg::OP_LEVEL, 16'd13, 16'd7, 16'd1, 4'd0, 5'd0);
		send_query(tmsc_pkg::OP_CHAIN, 16'd1024, 16'd1024, 16'd1, 4'd0, 5'd11);
		send_query(tmsc_pkg::OP_LEVEL, 16'd5, 16'd5, 16'd3, 4'd1, 5'd0);
		drain_results();
		set_format(5'd16, 5'd16, 5'd16);
		send_query(tmsc_pkg::OP_CHAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 5'd17);
		send_query(tmsc_pkg::OP_LEVEL, 16'd17, 16'd15, 16'd2, 4'd0, 5'd0);
		drain_results();
		set_format(5'd0, 5'd4, 5'd16);
		send_query(tmsc_pkg::OP_LEVEL, 16'd64, 16'd64, 16'd1, 4'd0, 5'd0);
		send_query(tmsc_pkg::OP_CHAIN, 16'd64, 16'd64, 16'd1, 4'd0, 5'd7);
		drain_results();
		set_format(5'd4, 5'd0, 5'd16);
		send_query(tmsc_pkg::OP_LEVEL, 16'd64, 16'd64, 16'd1, 4'd2, 5'd0);
		drain_results();
		set_format(5'd12, 5'd5, 5'd0);
		send_query(tmsc_pkg::OP_CHAIN, 16'd300, 16'd200, 16'd9, 4'd0, 5'd9);
		drain_results();
		write_reg(tmsc_pkg::REG_BLOCK_WIDTH, 5'd31);
		write_reg(tmsc_pkg::REG_BLOCK_HEIGHT, 5'd31);
		write_reg(tmsc_pkg::REG_BYTES_PER_BLOCK, 5'd31);
		write_reg(REG_UNUSED, 5'd1);
		cfg_valid <= 1'b0;
		send_query(tmsc_pkg::OP_LEVEL, 16'd100, 16'd70, 16'd3, 4'd0, 5'd0);
		send_query(tmsc_pkg::OP_CHAIN, 16'd100, 16'd70, 16'd3, 4'd0, 5'd8);
		drain_results();
	endtask

	// Random requests over several formats, extremes first
	task automatic test_random_traffic();
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_format(5'd16, 5'd16, 5'd16);
				1: set_format(5'd1, 5'd1, 5'd1);
				2: set_format(5'd0, 5'd0, 5'd0);
				default: set_format(pick_block(), pick_block(), pick_block());
			endcase
			repeat (130) send_random_query();
			drain_results();
		end
	endtask

	// Both sides run with no idling for a long stretch
	task automatic test_back_to_back();
		set_format(5'd4, 5'd4, 5'd16);
		no_idle = 1'b1;
		repeat (150) send_random_query();
		drain_results();
		no_idle = 1'b0;
	endtask

	// Stall the result side at random unless a no-idle stretch is running
	always @(posedge clk)
		m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	// Compare each accepted result with the oldest expected size
	always @(posedge clk) begin : check_sizes
		size_expect_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sizes.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d", m_tdata));
			end else begin
				want = pending_sizes.pop_front();
				if (m_tdata !== want.size)
					report_mismatch($sformatf(
						"op %0d w %0d h %0d d %0d idx %0d cnt %0d got %0d want %0d",
						want.op, want.w, want.h, want.d, want.idx, want.cnt,
						m_tdata, want.size));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_levels();
		test_directed_formats();
		test_random_traffic();
		test_back_to_back();
		drain_results();
		repeat (90) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[texture_mip_size_calculator] OK");
		end else begin
			$display("[texture_mip_size_calculator] ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tmsc_pkg.sv
rtl/tmsc_datapath.sv
rtl/tmsc_ctrl.sv
rtl/texture_mip_size_calculator.sv
sim/texture_mip_size_calculator_tb.sv
